@@ src/pdl_pkg.sv @@
// ----------------------------------------------------------------------------
// pdl_pkg
// Widths, register codes and payload bundles shared by the depth limiter.
// ----------------------------------------------------------------------------
package pdl_pkg;

    localparam int DATA_W = 32;
    localparam int WID_W  = 31;
    localparam int FRAC_W = 16;
    localparam int QNUM_W = DATA_W + FRAC_W;
    localparam int H_W    = QNUM_W + 1;
    localparam int SUM_W  = H_W + 1;
    localparam int HN_W   = SUM_W + 1;
    localparam int MAG_W  = HN_W - 1;
    localparam int MB_W   = DATA_W;
    localparam int ADDR_W = 3;

    localparam logic REG_MIN_DEPTH      = 1'b0;
    localparam logic REG_DISCHARGE_ZERO = 1'b1;

    localparam logic [WID_W-1:0] MIN_DEPTH_RST      = 31'd65;
    localparam logic [WID_W-1:0] DISCHARGE_ZERO_RST = 31'd0;

    typedef struct packed {
        logic signed [DATA_W-1:0] a0;
        logic signed [DATA_W-1:0] a1;
        logic [WID_W-1:0]         b0;
        logic [WID_W-1:0]         b1;
        logic signed [DATA_W-1:0] q0;
        logic signed [DATA_W-1:0] q1;
        logic                     zw;
    } elem_t;

    typedef struct packed {
        elem_t e;
        logic  neg;
    } dh_side_t;

    typedef struct packed {
        elem_t                    e;
        logic signed [DATA_W-1:0] na0;
        logic signed [DATA_W-1:0] na1;
        logic                     neg;
    } dw_side_t;

    typedef struct packed {
        elem_t                    e;
        logic signed [DATA_W-1:0] na0;
    } m2_side_t;

endpackage

@@ src/pdl_ifs.sv @@
// ----------------------------------------------------------------------------
// pdl_ifs
// Element and result channels of the depth limiter.
// ----------------------------------------------------------------------------
interface pdl_elem_if;
    logic                             valid;
    logic                             ready;
    logic signed [pdl_pkg::DATA_W-1:0] area_left;
    logic signed [pdl_pkg::DATA_W-1:0] area_right;
    logic [pdl_pkg::WID_W-1:0]        width_left;
    logic [pdl_pkg::WID_W-1:0]        width_right;
    logic signed [pdl_pkg::DATA_W-1:0] flow_left;
    logic signed [pdl_pkg::DATA_W-1:0] flow_right;

    modport source (output valid, area_left, area_right, width_left, width_right,
                    flow_left, flow_right, input ready);
    modport sink (input valid, area_left, area_right, width_left, width_right,
                  flow_left, flow_right, output ready);
endinterface

interface pdl_result_if;
    logic                             valid;
    logic                             ready;
    logic signed [pdl_pkg::DATA_W-1:0] new_area_left;
    logic signed [pdl_pkg::DATA_W-1:0] new_area_right;
    logic signed [pdl_pkg::DATA_W-1:0] new_flow_left;
    logic signed [pdl_pkg::DATA_W-1:0] new_flow_right;
    logic                             status;

    modport source (output valid, new_area_left, new_area_right, new_flow_left,
                    new_flow_right, status, input ready);
    modport sink (input valid, new_area_left, new_area_right, new_flow_left,
                  new_flow_right, status, output ready);
endinterface

@@ src/pdl_div.sv @@
// ----------------------------------------------------------------------------
// pdl_div
// Pipelined restoring divider, one quotient bit per stage, with sideband.
// ----------------------------------------------------------------------------
module pdl_div #(
    parameter int NW = 48,
    parameter int DW = 31,
    parameter int SW = 1
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic          in_valid,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    input  logic [SW-1:0] side,
    output logic          out_valid,
    output logic [NW-1:0] quo,
    output logic [SW-1:0] side_out
);

    logic          valid_reg [NW];
    logic [NW-1:0] num_reg   [NW];
    logic [NW-1:0] quo_reg   [NW];
    logic [DW-1:0] rem_reg   [NW];
    logic [DW-1:0] den_reg   [NW];
    logic [SW-1:0] side_reg  [NW];

    for (genvar k = 0; k < NW; k++)
    begin : g_step
        logic          vin;
        logic [NW-1:0] nin;
        logic [NW-1:0] qin;
        logic [DW-1:0] rin;
        logic [DW-1:0] din;
        logic [SW-1:0] sin;
        logic [DW:0]   trial;
        logic          ge;

        if (k == 0)
        begin : g_first
            assign vin = in_valid;
            assign nin = num;
            assign qin = '0;
            assign rin = '0;
            assign din = den;
            assign sin = side;
        end
        else
        begin : g_next
            assign vin = valid_reg[k-1];
            assign nin = num_reg[k-1];
            assign qin = quo_reg[k-1];
            assign rin = rem_reg[k-1];
            assign din = den_reg[k-1];
            assign sin = side_reg[k-1];
        end

        assign trial = {rin, nin[NW-1]};
        assign ge    = trial >= {1'b0, din};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                valid_reg[k] <= vin;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                num_reg[k]  <= {nin[NW-2:0], 1'b0};
                quo_reg[k]  <= {qin[NW-2:0], ge};
                rem_reg[k]  <= ge ? DW'(trial - {1'b0, din}) : trial[DW-1:0];
                den_reg[k]  <= din;
                side_reg[k] <= sin;
            end
        end
    end

    assign out_valid = valid_reg[NW-1];
    assign quo       = quo_reg[NW-1];
    assign side_out  = side_reg[NW-1];

endmodule

@@ src/pdl_mul.sv @@
// ----------------------------------------------------------------------------
// pdl_mul
// Four-stage Q16.16 magnitude multiply with truncation and signed saturation.
// ----------------------------------------------------------------------------
module pdl_mul #(
    parameter int SW = 1
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             en,
    input  logic                             in_valid,
    input  logic [pdl_pkg::MAG_W-1:0]        ma,
    input  logic [pdl_pkg::MB_W-1:0]         mb,
    input  logic                             neg,
    input  logic [SW-1:0]                    side,
    output logic                             out_valid,
    output logic signed [pdl_pkg::DATA_W-1:0] res,
    output logic [SW-1:0]                    side_out
);
    import pdl_pkg::*;

    localparam int LO_W   = MAG_W / 2;
    localparam int HI_W   = MAG_W - LO_W;
    localparam int PL_W   = LO_W + MB_W;
    localparam int PH_W   = HI_W + MB_W;
    localparam int PROD_W = MAG_W + MB_W;
    localparam int R_W    = PROD_W - FRAC_W;
    localparam logic [R_W-1:0] POS_MAX = R_W'(32'h7FFF_FFFF);
    localparam logic [R_W-1:0] NEG_MAX = R_W'(32'h8000_0000);

    logic [3:0]        valid_reg;
    logic [HI_W-1:0]   hi1_reg;
    logic [MB_W-1:0]   mb1_reg;
    logic [PL_W-1:0]   plo1_reg, plo2_reg;
    logic [PH_W-1:0]   phi2_reg;
    logic [R_W-1:0]    r3_reg;
    logic [2:0]        neg_reg;
    logic [SW-1:0]     side1_reg, side2_reg, side3_reg, side4_reg;
    logic signed [DATA_W-1:0] res_reg, res_next;
    logic [PROD_W-1:0] prod_next;

    assign prod_next = {phi2_reg, {LO_W{1'b0}}} + PROD_W'(plo2_reg);

    always_comb
    begin
        if (neg_reg[2])
        begin
            res_next = (r3_reg > NEG_MAX) ? $signed(32'h8000_0000)
                                          : -$signed(r3_reg[DATA_W-1:0]);
        end
        else
        begin
            res_next = (r3_reg > POS_MAX) ? $signed(32'h7FFF_FFFF)
                                          : $signed(r3_reg[DATA_W-1:0]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            plo1_reg  <= PL_W'(ma[LO_W-1:0]) * PL_W'(mb);
            hi1_reg   <= ma[MAG_W-1:LO_W];
            mb1_reg   <= mb;
            phi2_reg  <= PH_W'(hi1_reg) * PH_W'(mb1_reg);
            plo2_reg  <= plo1_reg;
            r3_reg    <= prod_next[PROD_W-1:FRAC_W];
            neg_reg   <= {neg_reg[1:0], neg};
            res_reg   <= res_next;
            side1_reg <= side;
            side2_reg <= side1_reg;
            side3_reg <= side2_reg;
            side4_reg <= side3_reg;
        end
    end

    assign out_valid = valid_reg[3];
    assign res       = res_reg;
    assign side_out  = side4_reg;

endmodule

@@ src/positive_depth_limiter.sv @@
// ----------------------------------------------------------------------------
// positive_depth_limiter: wet/dry positive-depth limiter for two-node elements.
// Each accepted item reaches its result through two
// 48-stage divider pipelines and two 4-stage multiplier pipelines in series.
// Throughput is one item per cycle; the whole pipeline holds while a result
// waits. Reset clears all valid bits and loads the register defaults.
// ----------------------------------------------------------------------------
module positive_depth_limiter (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [pdl_pkg::ADDR_W-1:0]  paddr,
    input  logic [pdl_pkg::DATA_W-1:0]  pwdata,
    output logic [pdl_pkg::DATA_W-1:0]  prdata,
    output logic                        pready,
    pdl_elem_if.sink                    elem,
    pdl_result_if.source                result
);
    import pdl_pkg::*;

    logic [WID_W-1:0] min_depth_reg, discharge_zero_reg;
    logic             adv;
    logic             cfg_wr;

    logic signed [H_W-1:0]  hmin_h;
    logic signed [SUM_W-1:0] hmin_s;
    logic signed [HN_W-1:0]  hmin_n;

    assign hmin_h = {{(H_W-WID_W){1'b0}}, min_depth_reg};
    assign hmin_s = {{(SUM_W-WID_W){1'b0}}, min_depth_reg};
    assign hmin_n = {{(HN_W-WID_W){1'b0}}, min_depth_reg};

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_depth_reg      <= MIN_DEPTH_RST;
            discharge_zero_reg <= DISCHARGE_ZERO_RST;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[2])
                REG_MIN_DEPTH:      min_depth_reg      <= pwdata[WID_W-1:0];
                REG_DISCHARGE_ZERO: discharge_zero_reg <= pwdata[WID_W-1:0];
                default:            min_depth_reg      <= min_depth_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_MIN_DEPTH:      prdata = {1'b0, min_depth_reg};
            REG_DISCHARGE_ZERO: prdata = {1'b0, discharge_zero_reg};
            default:            prdata = '0;
        endcase
    end

    // Stage 0: input register.
    elem_t e_s0_reg, e_s0_next;
    logic  v_s0_reg;
    logic  v_out_reg;

    assign adv        = !v_out_reg || result.ready;
    assign elem.ready = adv;

    always_comb
    begin
        e_s0_next.a0 = elem.area_left;
        e_s0_next.a1 = elem.area_right;
        e_s0_next.b0 = elem.width_left;
        e_s0_next.b1 = elem.width_right;
        e_s0_next.q0 = elem.flow_left;
        e_s0_next.q1 = elem.flow_right;
        e_s0_next.zw = (elem.width_left == '0) || (elem.width_right == '0);
    end

    // Depth division.
    logic [DATA_W-1:0] am0, am1;
    logic              vh0, vh1;
    logic [QNUM_W-1:0] qh0, qh1;
    dh_side_t          sh0_in, sh0_out;
    logic              sh1_out;

    assign am0 = e_s0_reg.a0[DATA_W-1] ? DATA_W'(-e_s0_reg.a0) : DATA_W'(e_s0_reg.a0);
    assign am1 = e_s0_reg.a1[DATA_W-1] ? DATA_W'(-e_s0_reg.a1) : DATA_W'(e_s0_reg.a1);
    assign sh0_in.e   = e_s0_reg;
    assign sh0_in.neg = e_s0_reg.a0[DATA_W-1];

    pdl_div #(.NW(QNUM_W), .DW(WID_W), .SW($bits(dh_side_t))) u_div_h0 (
        .clk(clk), .rst_n(rst_n), .en(adv), .in_valid(v_s0_reg),
        .num({am0, {FRAC_W{1'b0}}}), .den(e_s0_reg.b0), .side(sh0_in),
        .out_valid(vh0), .quo(qh0), .side_out(sh0_out)
    );

    pdl_div #(.NW(QNUM_W), .DW(WID_W), .SW(1)) u_div_h1 (
        .clk(clk), .rst_n(rst_n), .en(adv), .in_valid(v_s0_reg),
        .num({am1, {FRAC_W{1'b0}}}), .den(e_s0_reg.b1), .side(e_s0_reg.a1[DATA_W-1]),
        .out_valid(vh1), .quo(qh1), .side_out(sh1_out)
    );

    // Stages 1 to 4: depth limiting and multiplier operands.
    elem_t e_s1_reg, e_s2_reg, e_s3_reg, e_s4_reg;
    logic  v_s1_reg, v_s2_reg, v_s3_reg, v_s4_reg;
    logic signed [H_W-1:0]   h0_s1_reg, h1_s1_reg, h0_s1_next, h1_s1_next;
    logic signed [SUM_W-1:0] sum_s2_reg, sum_s2_next, sum_adj, avg;
    logic                    keep_s2_reg, le_s2_reg, keep_s3_reg, keep_s4_reg;
    logic signed [HN_W-1:0]  hn0_s3_reg, hn1_s3_reg, hn0_s3_next, hn1_s3_next, dd;
    logic [MAG_W-1:0]        ma0_s4_reg, ma1_s4_reg;
    logic                    ng0_s4_reg, ng1_s4_reg;

    always_comb
    begin
        h0_s1_next = sh0_out.neg ? -$signed({1'b0, qh0}) : $signed({1'b0, qh0});
        h1_s1_next = sh1_out ? -$signed({1'b0, qh1}) : $signed({1'b0, qh1});
        sum_s2_next = SUM_W'(h0_s1_reg) + SUM_W'(h1_s1_reg);
        sum_adj = sum_s2_reg + $signed({{(SUM_W-1){1'b0}}, sum_s2_reg[SUM_W-1]});
        avg = {sum_adj[SUM_W-1], sum_adj[SUM_W-1:1]};
        dd = HN_W'(sum_s2_reg) - hmin_n;
        priority if (avg <= hmin_s)
        begin
            hn0_s3_next = HN_W'(avg);
            hn1_s3_next = HN_W'(avg);
        end
        else if (le_s2_reg)
        begin
            hn0_s3_next = hmin_n;
            hn1_s3_next = dd;
        end
        else
        begin
            hn0_s3_next = dd;
            hn1_s3_next = hmin_n;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            e_s0_reg    <= e_s0_next;
            e_s1_reg    <= sh0_out.e;
            h0_s1_reg   <= h0_s1_next;
            h1_s1_reg   <= h1_s1_next;
            e_s2_reg    <= e_s1_reg;
            sum_s2_reg  <= sum_s2_next;
            keep_s2_reg <= (h0_s1_reg >= hmin_h) && (h1_s1_reg >= hmin_h);
            le_s2_reg   <= h0_s1_reg <= h1_s1_reg;
            e_s3_reg    <= e_s2_reg;
            keep_s3_reg <= keep_s2_reg;
            hn0_s3_reg  <= hn0_s3_next;
            hn1_s3_reg  <= hn1_s3_next;
            e_s4_reg    <= e_s3_reg;
            keep_s4_reg <= keep_s3_reg;
            ma0_s4_reg  <= hn0_s3_reg[HN_W-1] ? MAG_W'(-hn0_s3_reg) : MAG_W'(hn0_s3_reg);
            ma1_s4_reg  <= hn1_s3_reg[HN_W-1] ? MAG_W'(-hn1_s3_reg) : MAG_W'(hn1_s3_reg);
            ng0_s4_reg  <= hn0_s3_reg[HN_W-1];
            ng1_s4_reg  <= hn1_s3_reg[HN_W-1];
        end
    end

    // Area rebuild from limited depths.
    logic                     vm0, vm1, keep_m;
    logic signed [DATA_W-1:0] mr0, mr1;
    elem_t                    e_m;

    pdl_mul #(.SW($bits(elem_t))) u_mul_a0 (
        .clk(clk), .rst_n(rst_n), .en(adv), .in_valid(v_s4_reg),
        .ma(ma0_s4_reg), .mb({1'b0, e_s4_reg.b0}), .neg(ng0_s4_reg), .side(e_s4_reg),
        .out_valid(vm0), .res(mr0), .side_out(e_m)
    );

    pdl_mul #(.SW(1)) u_mul_a1 (
        .clk(clk), .rst_n(rst_n), .en(adv), .in_valid(v_s4_reg),
        .ma(ma1_s4_reg), .mb({1'b0, e_s4_reg.b1}), .neg(ng1_s4_reg), .side(keep_s4_reg),
        .out_valid(vm1), .res(mr1), .side_out(keep_m)
    );

    // Stage 5: new areas, then wet test and velocity divisions.
    elem_t                    e_s5_reg;
    logic                     v_s5_reg;
    logic signed [DATA_W-1:0] na0_s5_reg, na1_s5_reg;
    logic [DATA_W-1:0]        nm0, nm1, qm0, qm1;
    dw_side_t                 sw0_in, sw0_out;
    logic                     sw1_out, su0_out, su1_out;
    logic                     vw0, vw1, vu0, vu1;
    logic [QNUM_W-1:0]        qw0, qw1, qu0, qu1;

    assign nm0 = na0_s5_reg[DATA_W-1] ? DATA_W'(-na0_s5_reg) : DATA_W'(na0_s5_reg);
    assign nm1 = na1_s5_reg[DATA_W-1] ? DATA_W'(-na1_s5_reg) : DATA_W'(na1_s5_reg);
    assign qm0 = e_s5_reg.q0[DATA_W-1] ? DATA_W'(-e_s5_reg.q0) : DATA_W'(e_s5_reg.q0);
    assign qm1 = e_s5_reg.q1[DATA_W-1] ? DATA_W'(-e_s5_reg.q1) : DATA_W'(e_s5_reg.q1);
    assign sw0_in.e   = e_s5_reg;
    assign sw0_in.na0 = na0_s5_reg;
    assign sw0_in.na1 = na1_s5_reg;
    assign sw0_in.neg = na0_s5_reg[DATA_W-1];

    pdl_div #(.NW(QNUM_W), .DW(WID_W), .SW($bits(dw_side_t))) u_div_w0 (
        .clk(clk), .rst_n(rst_n), .en(adv), .in_valid(v_s5_reg),
        .num({nm0, {FRAC_W{1'b0}}}), .den(e_s5_reg.b0), .side(sw0_in),
        .out_valid(vw0), .quo(qw0), .side_out(sw0_out)
    );

    pdl_div #(.NW(QNUM_W), .DW(WID_W), .SW(1)) u_div_w1 (
        .clk(clk), .rst_n(rst_n), .en(adv), .in_valid(v_s5_reg),
        .num({nm1, {FRAC_W{1'b0}}}), .den(e_s5_reg.b1), .side(na1_s5_reg[DATA_W-1]),
        .out_valid(vw1), .quo(qw1), .side_out(sw1_out)
    );

    pdl_div #(.NW(QNUM_W), .DW(DATA_W), .SW(1)) u_div_u0 (
        .clk(clk), .rst_n(rst_n), .en(adv), .in_valid(v_s5_reg),
        .num({qm0, {FRAC_W{1'b0}}}), .den(nm0),
        .side(e_s5_reg.q0[DATA_W-1] ^ na0_s5_reg[DATA_W-1]),
        .out_valid(vu0), .quo(qu0), .side_out(su0_out)
    );

    pdl_div #(.NW(QNUM_W), .DW(DATA_W), .SW(1)) u_div_u1 (
        .clk(clk), .rst_n(rst_n), .en(adv), .in_valid(v_s5_reg),
        .num({qm1, {FRAC_W{1'b0}}}), .den(nm1),
        .side(e_s5_reg.q1[DATA_W-1] ^ na1_s5_reg[DATA_W-1]),
        .out_valid(vu1), .quo(qu1), .side_out(su1_out)
    );

    // Stages 7 to 10: wet flags, velocity redistribution, multiplier operands.
    elem_t                    e_s7_reg, e_s8_reg, e_s9_reg, e_s10_reg;
    logic                     v_s7_reg, v_s8_reg, v_s9_reg, v_s10_reg;
    logic signed [DATA_W-1:0] na0_s7_reg, na1_s7_reg, na0_s8_reg, na1_s8_reg;
    logic signed [DATA_W-1:0] na0_s9_reg, na1_s9_reg, na0_s10_reg, na1_s10_reg;
    logic                     w0_next, w1_next, c0_next, c1_next;
    logic                     w0_s7_reg, w1_s7_reg, c0_s7_reg, c1_s7_reg;
    logic                     w0_s8_reg, w1_s8_reg;
    logic signed [H_W-1:0]    u0_next, u1_next, u0_s7_reg, u1_s7_reg, u0_s8_reg, u1_s8_reg;
    logic signed [SUM_W-1:0]  del_s8_reg, del_s8_next;
    logic signed [HN_W-1:0]   un0_s9_reg, un1_s9_reg, un0_s9_next, un1_s9_next;
    logic [DATA_W-1:0]        fm0, fm1;
    logic [MAG_W-1:0]         mu0_s10_reg, mu1_s10_reg;
    logic                     ngu0_s10_reg, ngu1_s10_reg;

    assign fm0 = sw0_out.e.q0[DATA_W-1] ? DATA_W'(-sw0_out.e.q0) : DATA_W'(sw0_out.e.q0);
    assign fm1 = sw0_out.e.q1[DATA_W-1] ? DATA_W'(-sw0_out.e.q1) : DATA_W'(sw0_out.e.q1);

    always_comb
    begin
        w0_next = !sw0_out.neg && (qw0 > QNUM_W'(min_depth_reg));
        w1_next = !sw1_out && (qw1 > QNUM_W'(min_depth_reg));
        u0_next = (sw0_out.na0 == '0) ? '0 :
                  (su0_out ? -$signed({1'b0, qu0}) : $signed({1'b0, qu0}));
        u1_next = (sw0_out.na1 == '0) ? '0 :
                  (su1_out ? -$signed({1'b0, qu1}) : $signed({1'b0, qu1}));
        c0_next = !w0_next && (fm0 > DATA_W'(discharge_zero_reg));
        c1_next = !w1_next && (fm1 > DATA_W'(discharge_zero_reg));
        del_s8_next = (c0_s7_reg ? SUM_W'(u0_s7_reg) : '0)
                    + (c1_s7_reg ? SUM_W'(u1_s7_reg) : '0);
        un0_s9_next = w0_s8_reg ? HN_W'(u0_s8_reg) + HN_W'(del_s8_reg) : '0;
        un1_s9_next = w1_s8_reg ? HN_W'(u1_s8_reg) + HN_W'(del_s8_reg) : '0;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            e_s5_reg     <= e_m;
            na0_s5_reg   <= keep_m ? e_m.a0 : mr0;
            na1_s5_reg   <= keep_m ? e_m.a1 : mr1;
            e_s7_reg     <= sw0_out.e;
            na0_s7_reg   <= sw0_out.na0;
            na1_s7_reg   <= sw0_out.na1;
            w0_s7_reg    <= w0_next;
            w1_s7_reg    <= w1_next;
            c0_s7_reg    <= c0_next;
            c1_s7_reg    <= c1_next;
            u0_s7_reg    <= u0_next;
            u1_s7_reg    <= u1_next;
            e_s8_reg     <= e_s7_reg;
            na0_s8_reg   <= na0_s7_reg;
            na1_s8_reg   <= na1_s7_reg;
            w0_s8_reg    <= w0_s7_reg;
            w1_s8_reg    <= w1_s7_reg;
            u0_s8_reg    <= u0_s7_reg;
            u1_s8_reg    <= u1_s7_reg;
            del_s8_reg   <= del_s8_next;
            e_s9_reg     <= e_s8_reg;
            na0_s9_reg   <= na0_s8_reg;
            na1_s9_reg   <= na1_s8_reg;
            un0_s9_reg   <= un0_s9_next;
            un1_s9_reg   <= un1_s9_next;
            e_s10_reg    <= e_s9_reg;
            na0_s10_reg  <= na0_s9_reg;
            na1_s10_reg  <= na1_s9_reg;
            mu0_s10_reg  <= un0_s9_reg[HN_W-1] ? MAG_W'(-un0_s9_reg) : MAG_W'(un0_s9_reg);
            mu1_s10_reg  <= un1_s9_reg[HN_W-1] ? MAG_W'(-un1_s9_reg) : MAG_W'(un1_s9_reg);
            ngu0_s10_reg <= un0_s9_reg[HN_W-1] ^ na0_s9_reg[DATA_W-1];
            ngu1_s10_reg <= un1_s9_reg[HN_W-1] ^ na1_s9_reg[DATA_W-1];
        end
    end

    // Discharge rebuild.
    logic [DATA_W-1:0]        nb0, nb1;
    logic                     vf0, vf1;
    logic signed [DATA_W-1:0] fr0, fr1, na1_f;
    m2_side_t                 sf0_in, sf0_out;

    assign nb0 = na0_s10_reg[DATA_W-1] ? DATA_W'(-na0_s10_reg) : DATA_W'(na0_s10_reg);
    assign nb1 = na1_s10_reg[DATA_W-1] ? DATA_W'(-na1_s10_reg) : DATA_W'(na1_s10_reg);
    assign sf0_in.e   = e_s10_reg;
    assign sf0_in.na0 = na0_s10_reg;

    pdl_mul #(.SW($bits(m2_side_t))) u_mul_q0 (
        .clk(clk), .rst_n(rst_n), .en(adv), .in_valid(v_s10_reg),
        .ma(mu0_s10_reg), .mb(nb0), .neg(ngu0_s10_reg), .side(sf0_in),
        .out_valid(vf0), .res(fr0), .side_out(sf0_out)
    );

    pdl_mul #(.SW(DATA_W)) u_mul_q1 (
        .clk(clk), .rst_n(rst_n), .en(adv), .in_valid(v_s10_reg),
        .ma(mu1_s10_reg), .mb(nb1), .neg(ngu1_s10_reg), .side(na1_s10_reg),
        .out_valid(vf1), .res(fr1), .side_out(na1_f)
    );

    // Result register.
    logic signed [DATA_W-1:0] ra0_reg, ra1_reg, rq0_reg, rq1_reg;
    logic                     rst_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ra0_reg <= sf0_out.e.zw ? sf0_out.e.a0 : sf0_out.na0;
            ra1_reg <= sf0_out.e.zw ? sf0_out.e.a1 : na1_f;
            rq0_reg <= sf0_out.e.zw ? sf0_out.e.q0 : fr0;
            rq1_reg <= sf0_out.e.zw ? sf0_out.e.q1 : fr1;
            rst_reg <= sf0_out.e.zw;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_s0_reg  <= 1'b0;
            v_s1_reg  <= 1'b0;
            v_s2_reg  <= 1'b0;
            v_s3_reg  <= 1'b0;
            v_s4_reg  <= 1'b0;
            v_s5_reg  <= 1'b0;
            v_s7_reg  <= 1'b0;
            v_s8_reg  <= 1'b0;
            v_s9_reg  <= 1'b0;
            v_s10_reg <= 1'b0;
            v_out_reg <= 1'b0;
        end
        else if (adv)
        begin
            v_s0_reg  <= elem.valid;
            v_s1_reg  <= vh0;
            v_s2_reg  <= v_s1_reg;
            v_s3_reg  <= v_s2_reg;
            v_s4_reg  <= v_s3_reg;
            v_s5_reg  <= vm0;
            v_s7_reg  <= vw0;
            v_s8_reg  <= v_s7_reg;
            v_s9_reg  <= v_s8_reg;
            v_s10_reg <= v_s9_reg;
            v_out_reg <= vf0;
        end
    end

    assign result.valid          = v_out_reg;
    assign result.new_area_left  = ra0_reg;
    assign result.new_area_right = ra1_reg;
    assign result.new_flow_left  = rq0_reg;
    assign result.new_flow_right = rq1_reg;
    assign result.status         = rst_reg;

`ifndef NO_ASSERTIONS
    a_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
        (vh0 == vh1) && (vm0 == vm1) && (vw0 == vw1) && (vw0 == vu0) && (vw0 == vu1)
        && (vf0 == vf1))
        else $error("parallel units lost lockstep");

    a_dry_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && !result.status && (result.new_area_left == '0)
        |-> (result.new_flow_left == '0))
        else $error("zero area node carries discharge");

    a_cfg: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_wr && (paddr[2] == REG_MIN_DEPTH)
        |=> (min_depth_reg == $past(pwdata[WID_W-1:0])))
        else $error("min_depth write lost");

    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !result.valid |-> elem.ready)
        else $error("input stalled with empty result register");
`endif

endmodule

@@ tb/sv/tb_positive_depth_limiter.sv @@
// ----------------------------------------------------------------------------
// tb_positive_depth_limiter
// Streams two-node elements through the depth limiter under random idling on
// both sides and checks every result field against an in-bench predictor,
// across several register settings written over the APB port.
// ----------------------------------------------------------------------------
module tb_positive_depth_limiter;

    import pdl_pkg::*;

    typedef struct {
        logic signed [DATA_W-1:0] al;
        logic signed [DATA_W-1:0] ar;
        logic [WID_W-1:0]         wl;
        logic [WID_W-1:0]         wr;
        logic signed [DATA_W-1:0] fl;
        logic signed [DATA_W-1:0] fr;
    } element_t;

    typedef struct {
        logic signed [DATA_W-1:0] nal;
        logic signed [DATA_W-1:0] nar;
        logic signed [DATA_W-1:0] nfl;
        logic signed [DATA_W-1:0] nfr;
        logic                     st;
    } limited_t;

    localparam int LATENCY = 115;

    logic              clk;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    pdl_elem_if   elem ();
    pdl_result_if result ();

    positive_depth_limiter i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .elem    (elem.sink),
        .result  (result.sink)
    );

    element_t elem_queue[$];
    limited_t pending_results[$];
    longint   min_depth_cfg = 65;
    longint   dz_cfg = 0;
    int       errors = 0;
    int       results_seen = 0;
    bit       steady = 0;
    bit       long_hold_done = 0;
    int       send_gap = 0;
    int       recv_gap = 0;

    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic longint depth_of(longint num, longint den);
        return (num * 65536) / den;
    endfunction

    function automatic longint scale_sat(longint a, longint b);
        bit                  neg;
        longint unsigned     ma;
        longint unsigned     mb;
        longint unsigned     hi;
        longint unsigned     lo;
        longint unsigned     r;
        neg = (a < 0) != (b < 0);
        ma = (a < 0) ? longint'(-a) : a;
        mb = (b < 0) ? longint'(-b) : b;
        hi = ma >> 16;
        lo = ma & 64'hFFFF;
        if (mb != 0 && hi > (64'd1 << 32) / mb)
            r = 64'd1 << 33;
        else
            r = hi * mb + ((lo * mb) >> 16);
        if (neg)
        begin
            if (r > 64'h8000_0000)
                return -64'sh8000_0000;
            return -longint'(r);
        end
        if (r > 64'h7FFF_FFFF)
            return 64'sh7FFF_FFFF;
        return longint'(r);
    endfunction

    function automatic longint magnitude(longint v);
        return v < 0 ? -v : v;
    endfunction

    function automatic limited_t limit_element(element_t e);
        limited_t res;
        longint   a0, a1, b0, b1, q0, q1, h0, h1, avg, na0, na1, u0, u1, del, npos;
        bit       w0, w1;
        a0 = e.al;
        a1 = e.ar;
        b0 = longint'(e.wl);
        b1 = longint'(e.wr);
        q0 = e.fl;
        q1 = e.fr;
        if (b0 == 0 || b1 == 0)
        begin
            res.nal = e.al;
            res.nar = e.ar;
            res.nfl = e.fl;
            res.nfr = e.fr;
            res.st  = 1'b1;
            return res;
        end
        h0 = depth_of(a0, b0);
        h1 = depth_of(a1, b1);
        avg = (h0 + h1) / 2;
        if (h0 >= min_depth_cfg && h1 >= min_depth_cfg)
        begin
            na0 = a0;
            na1 = a1;
        end
        else
        begin
            if (avg <= min_depth_cfg)
            begin
                h0 = avg;
                h1 = avg;
            end
            else if (h0 <= h1)
            begin
                h1 = h1 - (min_depth_cfg - h0);
                h0 = min_depth_cfg;
            end
            else
            begin
                h0 = h0 - (min_depth_cfg - h1);
                h1 = min_depth_cfg;
            end
            na0 = scale_sat(h0, b0);
            na1 = scale_sat(h1, b1);
        end
        w0 = depth_of(na0, b0) > min_depth_cfg;
        w1 = depth_of(na1, b1) > min_depth_cfg;
        u0 = (na0 != 0) ? depth_of(q0, na0) : 0;
        u1 = (na1 != 0) ? depth_of(q1, na1) : 0;
        if (!w0 && !w1)
        begin
            u0 = 0;
            u1 = 0;
        end
        else
        begin
            npos = longint'(w0) + longint'(w1);
            del = 0;
            if (!w0 && magnitude(q0) > dz_cfg)
                del += u0;
            if (!w1 && magnitude(q1) > dz_cfg)
                del += u1;
            del = del / npos;
            u0 = w0 ? u0 + del : 0;
            u1 = w1 ? u1 + del : 0;
        end
        res.nal = na0[31:0];
        res.nar = na1[31:0];
        res.nfl = DATA_W'(scale_sat(u0, na0));
        res.nfr = DATA_W'(scale_sat(u1, na1));
        res.st  = 1'b0;
        return res;
    endfunction

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(4, 40);
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        errors++;
        $display("mismatch on result %0d: %s got %0d expected %0d",
                 results_seen, what, got, want);
    endtask

    // Sender: offers the oldest pending item, with random gaps between items.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            elem.valid       <= 1'b0;
            elem.area_left   <= '0;
            elem.area_right  <= '0;
            elem.width_left  <= '0;
            elem.width_right <= '0;
            elem.flow_left   <= '0;
            elem.flow_right  <= '0;
            send_gap         <= 0;
        end
        else
        begin : sender
            bit       offer;
            int       gap;
            element_t nxt;
            gap = send_gap;
            if (elem.valid && elem.ready)
            begin
                pending_results.push_back(limit_element(elem_queue.pop_front()));
                gap = idle_len();
            end
            offer = 1'b0;
            if (gap > 0)
                gap--;
            else if (elem_queue.size() > 0)
            begin
                offer = 1'b1;
                nxt = elem_queue[0];
                elem.area_left   <= nxt.al;
                elem.area_right  <= nxt.ar;
                elem.width_left  <= nxt.wl;
                elem.width_right <= nxt.wr;
                elem.flow_left   <= nxt.fl;
                elem.flow_right  <= nxt.fr;
            end
            elem.valid <= offer;
            send_gap   <= gap;
        end
    end

    // Receiver: checks each result and stalls at random, once for a long stretch.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result.ready <= 1'b0;
            recv_gap     <= 0;
        end
        else
        begin : receiver
            limited_t want;
            int       gap;
            gap = recv_gap;
            if (result.valid && result.ready)
            begin
                if (pending_results.size() == 0)
                begin
                    errors++;
                    $display("unexpected result %0d", results_seen);
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (result.new_area_left !== want.nal)
                        report_mismatch("new_area_left", result.new_area_left, want.nal);
                    if (result.new_area_right !== want.nar)
                        report_mismatch("new_area_right", result.new_area_right, want.nar);
                    if (result.new_flow_left !== want.nfl)
                        report_mismatch("new_flow_left", result.new_flow_left, want.nfl);
                    if (result.new_flow_right !== want.nfr)
                        report_mismatch("new_flow_right", result.new_flow_right, want.nfr);
                    if (result.status !== want.st)
                        report_mismatch("status", result.status, want.st);
                end
                results_seen++;
                gap = idle_len();
                if (results_seen == 100 && !long_hold_done)
                begin
                    long_hold_done = 1'b1;
                    gap = 400;
                end
            end
            if (gap > 0)
            begin
                gap--;
                result.ready <= 1'b0;
            end
            else
                result.ready <= 1'b1;
            recv_gap <= gap;
        end
    end

    task automatic apb_write(logic [ADDR_W-1:0] addr, logic [DATA_W-1:0] data);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == ADDR_W'(4 * REG_MIN_DEPTH))
            min_depth_cfg = data & 32'h7FFF_FFFF;
        else
            dz_cfg = data & 32'h7FFF_FFFF;
    endtask

    task automatic set_limits(longint hmin, longint dz);
        apb_write(ADDR_W'(4 * REG_MIN_DEPTH), DATA_W'(hmin));
        apb_write(ADDR_W'(4 * REG_DISCHARGE_ZERO), DATA_W'(dz));
    endtask

    function automatic logic signed [DATA_W-1:0] clamp32(longint v);
        if (v > 64'sh7FFF_FFFF)
            return 32'sh7FFF_FFFF;
        if (v < -64'sh8000_0000)
            return 32'sh8000_0000;
        return v[31:0];
    endfunction

    function automatic logic signed [DATA_W-1:0] random_flow();
        int r;
        r = $urandom_range(0, 3);
        if (r == 0)
            return $urandom;
        if (r == 1)
            return clamp32(dz_cfg - 2 + $urandom_range(0, 4));
        if (r == 2)
            return clamp32(-dz_cfg - 2 + $urandom_range(0, 4));
        return $signed(DATA_W'($urandom_range(0, 1 << 22))) - (1 << 21);
    endfunction

    function automatic element_t random_element();
        element_t e;
        longint   span, d, w;
        int       r;
        r = $urandom_range(0, 99);
        e.fl = random_flow();
        e.fr = random_flow();
        if (r < 12)
        begin
            e.al = $urandom;
            e.ar = $urandom;
            e.wl = WID_W'($urandom);
            e.wr = WID_W'($urandom);
            e.fl = $urandom;
            e.fr = $urandom;
            return e;
        end
        span = min_depth_cfg * 3 + 4;
        if (span > 64'h7FFF_FFFF)
            span = 64'h7FFF_FFFF;
        w = $urandom_range(1, 1 << 20);
        d = longint'($urandom_range(0, 32'(span))) - min_depth_cfg / 2;
        e.wl = WID_W'(w);
        e.al = clamp32((d * w) / 65536);
        w = $urandom_range(1, 1 << 20);
        d = longint'($urandom_range(0, 32'(span))) - min_depth_cfg / 2;
        e.wr = WID_W'(w);
        e.ar = clamp32((d * w) / 65536);
        if (r < 16)
            e.wl = '0;
        else if (r < 20)
            e.wr = '0;
        else if (r < 23)
            e.al = '0;
        return e;
    endfunction

    function automatic element_t mk(longint al, longint ar, longint wl, longint wr,
                                    longint fl, longint fr);
        element_t e;
        e.al = al[31:0];
        e.ar = ar[31:0];
        e.wl = wl[30:0];
        e.wr = wr[30:0];
        e.fl = fl[31:0];
        e.fr = fr[31:0];
        return e;
    endfunction

    task automatic wait_drained();
        while (elem_queue.size() > 0 || pending_results.size() > 0)
            @(posedge clk);
        repeat (LATENCY + 20) @(posedge clk);
    endtask

    task automatic run_random(int n);
        repeat (n) elem_queue.push_back(random_element());
        wait_drained();
    endtask

    initial
    begin
        rst_n   = 1'b0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Directed elements under the reset thresholds.
        elem_queue.push_back(mk(1000, 2000, 0, 65536, 5, -5));
        elem_queue.push_back(mk(-7, 9, 65536, 0, 32'h7FFF_FFFF, -32'sh8000_0000));
        elem_queue.push_back(mk(65536, 131072, 65536, 65536, 1000, -1000));
        elem_queue.push_back(mk(10, 20, 65536, 65536, 300, -400));
        elem_queue.push_back(mk(30, 500, 65536, 65536, 300, 4000));
        elem_queue.push_back(mk(600, 40, 65536, 65536, -3000, 77));
        elem_queue.push_back(mk(0, 0, 65536, 65536, 100, 100));
        elem_queue.push_back(mk(0, 90000, 65536, 65536, 5000, 123456));
        elem_queue.push_back(mk(-500, 900, 65536, 65536, 12, 34));
        elem_queue.push_back(mk(32'h7FFF_FFFF, 32'h7FFF_FFFF, 1, 1,
                                32'h7FFF_FFFF, -32'sh8000_0000));
        elem_queue.push_back(mk(-32'sh8000_0000, -32'sh8000_0000, 1, 1,
                                -32'sh8000_0000, 32'h7FFF_FFFF));
        elem_queue.push_back(mk(-32'sh8000_0000, 32'h7FFF_FFFF, 31'h7FFF_FFFF,
                                31'h7FFF_FFFF, 1, -1));
        elem_queue.push_back(mk(1, 32'h7FFF_FFFF, 31'h7FFF_FFFF, 1, 32'h7FFF_FFFF, 0));
        elem_queue.push_back(mk(50, 32'h7FFF_FFFF, 65536, 1, 32'h7FFF_FFFF, 9));
        elem_queue.push_back(mk(2, 3, 1, 1, -32'sh8000_0000, -32'sh8000_0000));
        elem_queue.push_back(mk(64, 66, 65536, 65536, 1, -1));
        elem_queue.push_back(mk(65, 65, 65536, 65536, 0, 0));
        elem_queue.push_back(mk(0, 0, 0, 0, 0, 0));
        wait_drained();

        run_random(250);
        steady = 1'b1;
        run_random(80);
        steady = 1'b0;

        set_limits(0, 0);
        run_random(120);
        set_limits(32'h7FFF_FFFF, 32'h7FFF_FFFF);
        run_random(80);
        set_limits(65536, 1000);
        run_random(150);
        set_limits($urandom_range(1, 1 << 18), $urandom_range(0, 1 << 20));
        steady = 1'b1;
        run_random(60);
        steady = 1'b0;
        set_limits($urandom, $urandom);
        run_random(80);
        set_limits(65, 0);
        run_random(100);

        if (errors == 0)
            $display("PASS positive_depth_limiter");
        else
            $display("FAIL positive_depth_limiter");
        $finish;
    end

    initial
    begin
        #5000000;
        $display("FAIL positive_depth_limiter");
        $finish;
    end

endmodule
